FILE: design/clkreg_pkg.sv
// Shared types, codes and constants for the clock unit register block.
`default_nettype none

package clkreg_pkg;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [5:0]  word_index;
    logic [31:0] write_data;
  } access_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        in_range;
    logic        write_taken;
    logic        write_blocked;
    logic [31:0] main_clock_hz;
    logic        auto_wake;
    logic [31:0] taken_count;
    logic [31:0] blocked_count;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DECODE
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic result_busy;
  } status_t;

  localparam logic [5:0] W_GATE0 = 6'd0;
  localparam logic [5:0] W_GATE1 = 6'd1;
  localparam logic [5:0] W_CTRL  = 6'd2;
  localparam logic [5:0] W_PLL   = 6'd3;
  localparam logic [5:0] W_SSCG  = 6'd4;
  localparam logic [5:0] W_OPT   = 6'd5;
  localparam logic [5:0] W_KEY   = 6'd9;

  localparam logic [7:0] KEY_OPEN = 8'h96;

  localparam logic [31:0] RST_GATE0 = 32'h0000_0008;
  localparam logic [31:0] RST_GATE1 = 32'h3f0f_ffff;
  localparam logic [31:0] RST_CTRL  = 32'h0077_0003;
  localparam logic [31:0] RST_PLL   = 32'h0010_1804;
  localparam logic [31:0] RST_SSCG  = 32'h0000_f000;

  localparam logic [1:0] SRC_OSC1 = 2'd1;
  localparam logic [1:0] SRC_PLL  = 2'd3;

  function automatic logic [31:0] reset_word(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      W_GATE0: v = RST_GATE0;
      W_GATE1: v = RST_GATE1;
      W_CTRL:  v = RST_CTRL;
      W_PLL:   v = RST_PLL;
      W_SSCG:  v = RST_SSCG;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] osc3_shift(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'd0:    s = 3'd0;
      3'd1:    s = 3'd1;
      3'd2:    s = 3'd2;
      3'd3:    s = 3'd3;
      3'd4:    s = 3'd4;
      3'd5:    s = 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: design/clkreg_ctrl.sv
// Sequencer for capture, register update and clock decode of one bus word.
`default_nettype none

module clkreg_ctrl
  import clkreg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    access_valid,
  output logic         access_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    access_ready = 1'b0;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        access_ready = 1'b1;
        if (access_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (!status.result_busy) begin
          cmd.publish  = 1'b1;
          access_ready = 1'b1;
          if (access_valid) begin
            cmd.capture = 1'b1;
            state_next  = ST_EXEC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/clkreg_dp.sv
// Register file, key lock, write counters, clock decode and result register.
`default_nettype none

module clkreg_dp
  import clkreg_pkg::*;
#(
  parameter int unsigned REG_WORDS    = 16,
  parameter int unsigned OSC3_FREQ_HZ = 48000000,
  parameter int unsigned OSC1_FREQ_HZ = 32768
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cmd_t    cmd,
  input  wire access_t access,
  output status_t      status,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  localparam int unsigned IDX_W = $clog2(REG_WORDS);

  localparam logic [31:0] PLL_BASE [16] = '{
    32'(OSC3_FREQ_HZ / 1), 32'(OSC3_FREQ_HZ / 2), 32'(OSC3_FREQ_HZ / 3),
    32'(OSC3_FREQ_HZ / 4), 32'(OSC3_FREQ_HZ / 5), 32'(OSC3_FREQ_HZ / 6),
    32'(OSC3_FREQ_HZ / 7), 32'(OSC3_FREQ_HZ / 8), 32'(OSC3_FREQ_HZ / 9),
    32'(OSC3_FREQ_HZ / 10), 32'(OSC3_FREQ_HZ / 8), 32'(OSC3_FREQ_HZ / 8),
    32'(OSC3_FREQ_HZ / 8), 32'(OSC3_FREQ_HZ / 8), 32'(OSC3_FREQ_HZ / 8),
    32'(OSC3_FREQ_HZ / 8)
  };

  logic [31:0]          mem [REG_WORDS];
  logic [REG_WORDS-1:0] valid;
  logic [31:0]          mem_q;
  logic                 valid_q;
  access_t              item;

  logic [31:0] ctrl;
  logic [31:0] pll;
  logic [31:0] opt;
  logic [31:0] key;

  logic [31:0] taken_count;
  logic [31:0] blocked_count;
  logic [31:0] rd_hold;
  logic        inr_hold;
  logic        taken_hold;
  logic        blocked_hold;

  logic             acc_in_range;
  logic             inr;
  logic             wr_op;
  logic             take;
  logic             block;
  logic [31:0]      cur;
  logic [IDX_W-1:0] widx;

  logic [1:0]  sel;
  logic [36:0] hz_raw;
  logic [36:0] hz_half;
  logic [4:0]  mul;

  assign acc_in_range = {1'b0, access.word_index} < 7'(REG_WORDS);
  assign inr          = {1'b0, item.word_index} < 7'(REG_WORDS);
  assign wr_op        = item.mode == MODE_WRITE;
  assign take         = inr && wr_op && ((item.word_index == W_KEY) || (key[7:0] == KEY_OPEN));
  assign block        = inr && wr_op && !take;
  assign cur          = valid_q ? mem_q : reset_word(item.word_index);
  assign widx         = item.word_index[IDX_W-1:0];

  assign status.result_busy = result_valid && !result_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= access;
      if (acc_in_range) begin
        mem_q   <= mem[access.word_index[IDX_W-1:0]];
        valid_q <= valid[access.word_index[IDX_W-1:0]];
      end
    end
    if (cmd.exec && take) begin
      mem[widx] <= item.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      ctrl          <= RST_CTRL;
      pll           <= RST_PLL;
      opt           <= 32'h0;
      key           <= 32'h0;
      taken_count   <= 32'h0;
      blocked_count <= 32'h0;
    end else if (cmd.exec) begin
      if (take) begin
        valid[widx] <= 1'b1;
        taken_count <= taken_count + 32'd1;
        if (item.word_index == W_CTRL) begin
          ctrl <= item.write_data;
        end
        if (item.word_index == W_PLL) begin
          pll <= item.write_data;
        end
        if (item.word_index == W_OPT) begin
          opt <= item.write_data;
        end
        if (item.word_index == W_KEY) begin
          key <= item.write_data;
        end
      end
      if (block) begin
        blocked_count <= blocked_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_hold      <= (inr && !wr_op) ? cur : 32'h0;
      inr_hold     <= inr;
      taken_hold   <= take;
      blocked_hold <= block;
    end
  end

  assign sel = ctrl[3:2];
  assign mul = {1'b0, pll[7:4]} + 5'd1;

  always_comb begin
    case (sel)
      SRC_OSC1: begin
        hz_raw = ctrl[0] ? 37'(OSC1_FREQ_HZ) : 37'h0;
      end
      SRC_PLL: begin
        hz_raw = (pll[0] && ctrl[1]) ? 37'(PLL_BASE[ctrl[23:20]]) * 37'(mul) : 37'h0;
      end
      default: begin
        hz_raw = ctrl[1] ? (37'(OSC3_FREQ_HZ) >> osc3_shift(ctrl[10:8])) : 37'h0;
      end
    endcase
    hz_half = ctrl[12] ? (hz_raw >> 1) : hz_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.publish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result.read_data     <= rd_hold;
      result.in_range      <= inr_hold;
      result.write_taken   <= taken_hold;
      result.write_blocked <= blocked_hold;
      result.main_clock_hz <= hz_half[31:0];
      result.auto_wake     <= ~opt[0];
      result.taken_count   <= taken_count;
      result.blocked_count <= blocked_count;
    end
  end

endmodule

`default_nettype wire

FILE: design/clock_unit_registers_with_key_lock.sv
// Top level of the key-locked clock unit register block.
//
//   channel  | direction | payload   | handshake
//   access   | in        | access_t  | access_valid / access_ready
//   result   | out       | result_t  | result_valid / result_ready
//
// Each word reads the register file memory as it is captured, updates registers
// in the exec state and decodes the main clock through the PLL multiplier in the
// decode state, where a new word can already be taken as the result is published.
// Reset restores the datasheet defaults at once through per-word valid bits.
// A result held on the output stalls the decode cycle until it is taken.
`default_nettype none

module clock_unit_registers_with_key_lock
  import clkreg_pkg::*;
#(
  parameter int unsigned REG_WORDS    = 16,
  parameter int unsigned OSC3_FREQ_HZ = 48000000,
  parameter int unsigned OSC1_FREQ_HZ = 32768
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    access_valid,
  output logic         access_ready,
  input  wire access_t access,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  cmd_t    cmd;
  status_t status;

  clkreg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_ready (access_ready),
    .status       (status),
    .cmd          (cmd)
  );

  clkreg_dp #(
    .REG_WORDS    (REG_WORDS),
    .OSC3_FREQ_HZ (OSC3_FREQ_HZ),
    .OSC1_FREQ_HZ (OSC1_FREQ_HZ)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .access       (access),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: dv/clock_unit_registers_with_key_lock_tb.sv
// Testbench for the key-locked clock unit register block: directed and random bus words.
`default_nettype none

module clock_unit_registers_with_key_lock_tb;
  import clkreg_pkg::*;

  localparam int unsigned REG_WORDS    = 16;
  localparam int unsigned OSC3_FREQ_HZ = 48000000;
  localparam int unsigned OSC1_FREQ_HZ = 32768;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic    clk;
  logic    rst;
  logic    access_valid;
  logic    access_ready;
  access_t access;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  logic [31:0] reg_copy [REG_WORDS];
  logic [31:0] taken_total;
  logic [31:0] blocked_total;
  result_t     reply_q [$];
  result_t     want;
  int unsigned err_count;
  bit          calm;

  clock_unit_registers_with_key_lock #(
    .REG_WORDS   (REG_WORDS),
    .OSC3_FREQ_HZ(OSC3_FREQ_HZ),
    .OSC1_FREQ_HZ(OSC1_FREQ_HZ)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .access_valid(access_valid),
    .access_ready(access_ready),
    .access      (access),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] main_clock_of(input logic [31:0] ctl, input logic [31:0] pll);
    logic [63:0] hz;
    logic [3:0]  s;
    logic [63:0] indiv;
    hz = '0;
    if (ctl[3:2] == SRC_OSC1) begin
      hz = ctl[0] ? 64'(OSC1_FREQ_HZ) : 64'd0;
    end else if (ctl[3:2] == SRC_PLL) begin
      if (pll[0] && ctl[1]) begin
        s = ctl[23:20];
        indiv = (s <= 4'd9) ? 64'(s) + 64'd1 : 64'd8;
        hz = (64'(OSC3_FREQ_HZ) / indiv) * (64'(pll[7:4]) + 64'd1);
      end
    end else if (ctl[1]) begin
      hz = (ctl[10:8] <= 3'd5) ? 64'(OSC3_FREQ_HZ) >> ctl[10:8] : 64'(OSC3_FREQ_HZ);
    end
    if (ctl[12]) hz = hz / 2;
    return hz[31:0];
  endfunction

  function automatic result_t apply_access(input access_t a);
    result_t r;
    r = '0;
    r.in_range = (a.word_index < REG_WORDS);
    if (r.in_range) begin
      if (a.mode == MODE_WRITE) begin
        if (a.word_index != W_KEY && reg_copy[W_KEY][7:0] != KEY_OPEN) begin
          blocked_total = blocked_total + 1;
          r.write_blocked = 1'b1;
        end else begin
          reg_copy[a.word_index] = a.write_data;
          taken_total = taken_total + 1;
          r.write_taken = 1'b1;
        end
      end else begin
        r.read_data = reg_copy[a.word_index];
      end
    end
    r.main_clock_hz = main_clock_of(reg_copy[W_CTRL], reg_copy[W_PLL]);
    r.auto_wake     = ~reg_copy[W_OPT][0];
    r.taken_count   = taken_total;
    r.blocked_count = blocked_total;
    return r;
  endfunction

  task automatic send_word(input mode_t m, input logic [5:0] idx, input logic [31:0] data);
    int unsigned gap;
    gap = (!calm && $urandom_range(99) < 30) ? $urandom_range(4, 1) : 0;
    @(negedge clk);
    if (gap != 0) begin
      access_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    access_valid <= 1'b1;
    access       <= {m, idx, data};
    do @(posedge clk); while (!access_ready);
    reply_q.push_back(apply_access(access));
  endtask

  task automatic drain();
    @(negedge clk);
    access_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(negedge clk) begin
    result_ready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (reply_q.size() == 0) begin
        $error("result word with none expected");
        err_count++;
      end else begin
        want = reply_q.pop_front();
        check_field("read_data", want.read_data, result.read_data);
        check_field("in_range", 32'(want.in_range), 32'(result.in_range));
        check_field("write_taken", 32'(want.write_taken), 32'(result.write_taken));
        check_field("write_blocked", 32'(want.write_blocked), 32'(result.write_blocked));
        check_field("main_clock_hz", want.main_clock_hz, result.main_clock_hz);
        check_field("auto_wake", 32'(want.auto_wake), 32'(result.auto_wake));
        check_field("taken_count", want.taken_count, result.taken_count);
        check_field("blocked_count", want.blocked_count, result.blocked_count);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  task automatic test_reset_defaults();
    send_word(MODE_READ, W_GATE0, 32'h0);
    send_word(MODE_READ, W_GATE1, 32'h0);
    send_word(MODE_READ, W_CTRL, 32'h0);
    send_word(MODE_READ, W_PLL, 32'h0);
    send_word(MODE_READ, W_SSCG, 32'h0);
    send_word(MODE_READ, W_OPT, 32'h0);
    send_word(MODE_READ, W_KEY, 32'h0);
    send_word(MODE_READ, 6'd63, 32'h0);
  endtask

  task automatic test_locked_writes();
    send_word(MODE_WRITE, W_CTRL, 32'hffff_ffff);
    send_word(MODE_WRITE, 6'(REG_WORDS), 32'h1234_5678);
    send_word(MODE_READ, W_CTRL, 32'h0);
  endtask

  task automatic test_key_unlock();
    send_word(MODE_WRITE, W_KEY, 32'(KEY_OPEN));
    send_word(MODE_WRITE, W_CTRL, 32'h0);
    send_word(MODE_WRITE, W_OPT, 32'h0000_0001);
    send_word(MODE_READ, W_OPT, 32'h0);
    send_word(MODE_WRITE, 6'd63, 32'hdead_beef);
    send_word(MODE_READ, 6'(REG_WORDS - 1), 32'h0);
    send_word(MODE_WRITE, W_KEY, {24'hffff_ff, KEY_OPEN});
    send_word(MODE_WRITE, W_GATE0, 32'hffff_ffff);
    send_word(MODE_WRITE, W_KEY, 32'hffff_ff69);
    send_word(MODE_WRITE, W_GATE0, 32'h0);
    send_word(MODE_READ, W_GATE0, 32'h0);
  endtask

  task automatic test_clock_decode();
    send_word(MODE_WRITE, W_KEY, 32'(KEY_OPEN));
    send_word(MODE_WRITE, W_PLL, 32'hffff_ffff);
    send_word(MODE_WRITE, W_CTRL, 32'h0000_000e);
    send_word(MODE_WRITE, W_CTRL, 32'h00f0_100e);
    send_word(MODE_WRITE, W_CTRL, 32'h0000_0507);
    send_word(MODE_WRITE, W_CTRL, 32'h0000_0502);
    send_word(MODE_WRITE, W_CTRL, 32'h0000_060a);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned pick;
    mode_t       m;
    logic [5:0]  idx;
    logic [31:0] data;
    repeat (count) begin
      pick = $urandom_range(99);
      data = $urandom();
      if (pick < 15) begin
        m   = MODE_WRITE;
        idx = W_KEY;
        if ($urandom_range(9) < 7) data[7:0] = KEY_OPEN;
      end else if (pick < 50) begin
        m = MODE_WRITE;
        case ($urandom_range(2))
          0:       idx = W_CTRL;
          1:       idx = W_PLL;
          default: idx = W_OPT;
        endcase
      end else if (pick < 70) begin
        m   = MODE_WRITE;
        idx = 6'($urandom_range(63));
      end else begin
        m   = MODE_READ;
        idx = ($urandom_range(9) < 8) ? 6'($urandom_range(REG_WORDS - 1))
                                      : 6'($urandom_range(63));
      end
      send_word(m, idx, data);
    end
  endtask

  initial begin
    int i;
    rst          = 1'b1;
    access_valid = 1'b0;
    access       = '0;
    result_ready = 1'b0;
    calm         = 1'b0;
    err_count    = 0;
    for (i = 0; i < REG_WORDS; i++) reg_copy[i] = '0;
    reg_copy[W_GATE0] = RST_GATE0;
    reg_copy[W_GATE1] = RST_GATE1;
    reg_copy[W_CTRL]  = RST_CTRL;
    reg_copy[W_PLL]   = RST_PLL;
    reg_copy[W_SSCG]  = RST_SSCG;
    taken_total   = '0;
    blocked_total = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_locked_writes();
    test_key_unlock();
    test_clock_decode();
    drain();
    test_random_traffic(1300);
    calm = 1'b1;
    test_random_traffic(300);
    calm = 1'b0;
    test_random_traffic(300);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
design/clkreg_pkg.sv
design/clkreg_ctrl.sv
design/clkreg_dp.sv
design/clock_unit_registers_with_key_lock.sv
dv/clock_unit_registers_with_key_lock_tb.sv
